// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the I2C master transaction block.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_RSVD  = 2'd3
    } t_action;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'd0,
        PH_START2      = 5'd1,
        PH_START3      = 5'd2,
        PH_WBIT_SET    = 5'd3,
        PH_WBIT_HIGH   = 5'd4,
        PH_WBIT_LOW    = 5'd5,
        PH_ACK_HIGH    = 5'd6,
        PH_ACK_SAMPLE  = 5'd7,
        PH_RBIT_HIGH   = 5'd8,
        PH_RBIT_SAMPLE = 5'd9,
        PH_MACK_SET    = 5'd10,
        PH_MACK_HIGH   = 5'd11,
        PH_MACK_LOW    = 5'd12,
        PH_STOP1       = 5'd13,
        PH_STOP2       = 5'd14,
        PH_STOP3       = 5'd15,
        PH_DONE        = 5'd16
    } t_phase;

    localparam int unsigned BITS_PER_BYTE = 8;

    // Byte position within a transaction.
    localparam logic [1:0] BYTE_ADDR  = 2'd0;
    localparam logic [1:0] BYTE_FIRST = 2'd1;
    localparam logic [1:0] BYTE_SECOND = 2'd2;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  bit_count;
        logic [1:0]  byte_index;
        logic [7:0]  shift_byte;
        logic        is_read;
        logic [7:0]  held_data;
        logic [15:0] read_word;
        logic        nack_seen;
        logic        scl;
        logic        sda;
        logic        sda_drive;
    } t_state;

    localparam t_state C_STATE_RST = '{
        phase:      PH_IDLE,
        bit_count:  4'd0,
        byte_index: BYTE_ADDR,
        shift_byte: 8'd0,
        is_read:    1'b0,
        held_data:  8'd0,
        read_word:  16'd0,
        nack_seen:  1'b0,
        scl:        1'b1,
        sda:        1'b1,
        sda_drive:  1'b0
    };

endpackage

// ===== sv/i2cm_if.sv =====
// ----------------------------------------------------------------------------
// i2cm_in_if / i2cm_out_if
// Valid/ready channels carrying tick words in and bus status words out.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [6:0] target_addr;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, output action, output target_addr,
                    output write_data, output sda_in, input ready);
    modport sink   (input valid, input action, input target_addr,
                    input write_data, input sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic        valid;
    logic        ready;
    logic        scl;
    logic        sda_level;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_word;
    logic        nack;

    modport source (output valid, output scl, output sda_level, output sda_drive,
                    output busy_res, output done_res, output read_word,
                    output nack, input ready);
    modport sink   (input valid, input scl, input sda_level, input sda_drive,
                    input busy_res, input done_res, input read_word,
                    input nack, output ready);
endinterface

// ===== sv/i2c_master_transaction_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transaction_top
// I2C master sequencer: each input word is one bus phase tick, each output
// word shows the bus pins and status after that tick.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  i_in      in   action, target_addr, write_data, sda_in
//  o_out     out  scl, sda_level, sda_drive, busy_res, done_res, read_word, nack
//
//  One word per clock cycle sustained while o_out is not stalled; the result
//  appears in the cycle after the tick is taken, from the output register.
//  The sequencer state register is the only loop: one step per tick.
//  i_in.ready drops only while the output register is full and o_out is stalled.
//  Synchronous active-low reset returns the sequencer to idle, SCL/SDA high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2c_master_transaction_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cm_in_if.sink       i_in,
    i2cm_out_if.source    o_out
);
    import i2cm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   n_done;
    logic   in_ready;
    logic   accept;

    logic        r_out_valid;
    logic        r_scl;
    logic        r_sda;
    logic        r_sda_drive;
    logic        r_busy;
    logic        r_done;
    logic [15:0] r_read_word;
    logic        r_nack;

    i2cm_step u_step (
        .i_state       (r_state),
        .i_action      (i_in.action),
        .i_target_addr (i_in.target_addr),
        .i_write_data  (i_in.write_data),
        .i_sda_in      (i_in.sda_in),
        .o_state       (n_state),
        .o_done        (n_done)
    );

    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_STATE_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result word: hold until taken
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scl       <= n_state.scl;
            r_sda       <= n_state.sda;
            r_sda_drive <= n_state.sda_drive;
            r_busy      <= (n_state.phase != PH_IDLE);
            r_done      <= n_done;
            r_read_word <= n_state.read_word;
            r_nack      <= n_state.nack_seen;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.scl       = r_scl;
    assign o_out.sda_level = r_sda;
    assign o_out.sda_drive = r_sda_drive;
    assign o_out.busy_res  = r_busy;
    assign o_out.done_res  = r_done;
    assign o_out.read_word = r_read_word;
    assign o_out.nack      = r_nack;

    `ASSERT_IMPL(a_idle_bus_high, i_clk, i_rst_n, r_state.phase == PH_IDLE, r_state.scl && r_state.sda)
    `ASSERT_IMPL(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_done, !r_busy)
    `ASSERT_IMPL(a_bit_count_range, i_clk, i_rst_n, 1'b1, r_state.bit_count <= 4'(BITS_PER_BYTE))
    `ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, accept && r_state.phase == PH_DONE, r_state.phase == PH_IDLE)

endmodule

// ===== sv/i2cm_step.sv =====
// ----------------------------------------------------------------------------
// i2cm_step
// Next-state logic of the bus sequencer: one phase tick per call.
// ----------------------------------------------------------------------------
module i2cm_step (
    input  i2cm_pkg::t_state i_state,
    input  logic [1:0]       i_action,
    input  logic [6:0]       i_target_addr,
    input  logic [7:0]       i_write_data,
    input  logic             i_sda_in,
    output i2cm_pkg::t_state o_state,
    output logic             o_done
);
    import i2cm_pkg::*;

    logic [3:0] bit_inc;
    logic       byte_end;

    assign bit_inc  = i_state.bit_count + 4'd1;
    assign byte_end = (bit_inc >= 4'(BITS_PER_BYTE));

    always_comb begin
        o_state = i_state;
        o_done  = 1'b0;
        unique case (i_state.phase)
            PH_IDLE: begin
                if (i_action == ACT_WRITE || i_action == ACT_READ) begin
                    o_state.is_read    = (i_action == ACT_READ);
                    o_state.shift_byte = {i_target_addr, (i_action == ACT_READ)};
                    o_state.held_data  = i_write_data;
                    o_state.byte_index = BYTE_ADDR;
                    o_state.bit_count  = 4'd0;
                    o_state.nack_seen  = 1'b0;
                    o_state.read_word  = 16'd0;
                    o_state.sda_drive  = 1'b1;
                    o_state.sda        = 1'b1;
                    o_state.scl        = 1'b1;
                    o_state.phase      = PH_START2;
                end
            end
            PH_START2: begin
                o_state.sda   = 1'b0;
                o_state.phase = PH_START3;
            end
            PH_START3: begin
                o_state.scl       = 1'b0;
                o_state.bit_count = 4'd0;
                o_state.phase     = PH_WBIT_SET;
            end
            PH_WBIT_SET: begin
                o_state.sda_drive = 1'b1;
                o_state.sda       = i_state.shift_byte[7];
                o_state.phase     = PH_WBIT_HIGH;
            end
            PH_WBIT_HIGH: begin
                o_state.scl   = 1'b1;
                o_state.phase = PH_WBIT_LOW;
            end
            PH_WBIT_LOW: begin
                o_state.scl        = 1'b0;
                o_state.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                o_state.bit_count  = bit_inc;
                o_state.phase      = byte_end ? PH_ACK_HIGH : PH_WBIT_SET;
            end
            PH_ACK_HIGH: begin
                o_state.sda_drive = 1'b0;
                o_state.scl       = 1'b1;
                o_state.phase     = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE: begin
                o_state.nack_seen = i_state.nack_seen | i_sda_in;
                o_state.scl       = 1'b0;
                o_state.bit_count = 4'd0;
                if (i_state.byte_index == BYTE_ADDR) begin
                    o_state.byte_index = BYTE_FIRST;
                    if (i_state.is_read) begin
                        o_state.shift_byte = 8'd0;
                        o_state.phase      = PH_RBIT_HIGH;
                    end else begin
                        o_state.shift_byte = i_state.held_data;
                        o_state.phase      = PH_WBIT_SET;
                    end
                end else begin
                    o_state.phase = PH_STOP1;
                end
            end
            PH_RBIT_HIGH: begin
                o_state.sda_drive = 1'b0;
                o_state.scl       = 1'b1;
                o_state.phase     = PH_RBIT_SAMPLE;
            end
            PH_RBIT_SAMPLE: begin
                o_state.shift_byte = {i_state.shift_byte[6:0], i_sda_in};
                o_state.scl        = 1'b0;
                o_state.bit_count  = bit_inc;
                o_state.phase      = byte_end ? PH_MACK_SET : PH_RBIT_HIGH;
            end
            PH_MACK_SET: begin
                o_state.sda_drive = 1'b1;
                // ack the first byte, nack the last
                if (i_state.byte_index == BYTE_FIRST) begin
                    o_state.read_word = {i_state.shift_byte, 8'd0};
                    o_state.sda       = 1'b0;
                end else begin
                    o_state.read_word = {i_state.read_word[15:8], i_state.shift_byte};
                    o_state.sda       = 1'b1;
                end
                o_state.phase = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                o_state.scl   = 1'b1;
                o_state.phase = PH_MACK_LOW;
            end
            PH_MACK_LOW: begin
                o_state.scl = 1'b0;
                if (i_state.byte_index == BYTE_FIRST) begin
                    o_state.byte_index = BYTE_SECOND;
                    o_state.shift_byte = 8'd0;
                    o_state.bit_count  = 4'd0;
                    o_state.phase      = PH_RBIT_HIGH;
                end else begin
                    o_state.phase = PH_STOP1;
                end
            end
            PH_STOP1: begin
                o_state.sda_drive = 1'b1;
                o_state.scl       = 1'b0;
                o_state.sda       = 1'b0;
                o_state.phase     = PH_STOP2;
            end
            PH_STOP2: begin
                o_state.scl   = 1'b1;
                o_state.phase = PH_STOP3;
            end
            PH_STOP3: begin
                o_state.sda   = 1'b1;
                o_state.phase = PH_DONE;
            end
            PH_DONE: begin
                o_done        = 1'b1;
                o_state.phase = PH_IDLE;
            end
            default: begin
                o_state.phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== tb/i2c_master_transaction_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_top_tb
// Drives bus phase ticks into the I2C master and checks every status word
// against a tick-level model kept in the bench. A slave is mimicked by
// choosing sda_in from the modeled phase: acks, nacks and read data land in
// the sample ticks, noise elsewhere. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module i2c_master_transaction_top_tb;
    import i2cm_pkg::*;

    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_TICKS = 180;

    typedef struct packed {
        logic        scl;
        logic        sda_level;
        logic        sda_drive;
        logic        busy;
        logic        done;
        logic [15:0] read_word;
        logic        nack;
    } t_bus_pins;

    logic i_clk;
    logic i_rst_n;

    i2cm_in_if  in_ch ();
    i2cm_out_if out_ch ();

    i2c_master_transaction_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_state    bus_st = C_STATE_RST;
    t_bus_pins expected_pins[$];
    int        mismatches   = 0;
    int        ticks_sent   = 0;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    int        hold_reqs    = 0;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Advance the bus model by one tick and return the pins it shows after.
    task automatic step_bus_model(input logic [1:0] act, input logic [6:0] addr,
                                  input logic [7:0] wdata, input logic sda,
                                  output t_bus_pins pins);
        logic done;
        done = 1'b0;
        case (bus_st.phase)
            PH_IDLE: begin
                if (act == ACT_WRITE || act == ACT_READ) begin
                    bus_st.is_read    = (act == ACT_READ);
                    bus_st.shift_byte = {addr, bus_st.is_read};
                    bus_st.held_data  = wdata;
                    bus_st.byte_index = BYTE_ADDR;
                    bus_st.bit_count  = 4'd0;
                    bus_st.nack_seen  = 1'b0;
                    bus_st.read_word  = 16'd0;
                    bus_st.sda_drive  = 1'b1;
                    bus_st.sda        = 1'b1;
                    bus_st.scl        = 1'b1;
                    bus_st.phase      = PH_START2;
                end
            end
            PH_START2: begin
                bus_st.sda   = 1'b0;
                bus_st.phase = PH_START3;
            end
            PH_START3: begin
                bus_st.scl       = 1'b0;
                bus_st.bit_count = 4'd0;
                bus_st.phase     = PH_WBIT_SET;
            end
            PH_WBIT_SET: begin
                bus_st.sda_drive = 1'b1;
                bus_st.sda       = bus_st.shift_byte[7];
                bus_st.phase     = PH_WBIT_HIGH;
            end
            PH_WBIT_HIGH: begin
                bus_st.scl   = 1'b1;
                bus_st.phase = PH_WBIT_LOW;
            end
            PH_WBIT_LOW: begin
                bus_st.scl        = 1'b0;
                bus_st.shift_byte = bus_st.shift_byte << 1;
                bus_st.bit_count  = bus_st.bit_count + 4'd1;
                bus_st.phase = (bus_st.bit_count >= BITS_PER_BYTE) ? PH_ACK_HIGH
                                                                   : PH_WBIT_SET;
            end
            PH_ACK_HIGH: begin
                bus_st.sda_drive = 1'b0;
                bus_st.scl       = 1'b1;
                bus_st.phase     = PH_ACK_SAMPLE;
            end
            PH_ACK_SAMPLE: begin
                if (sda)
                    bus_st.nack_seen = 1'b1;
                bus_st.scl       = 1'b0;
                bus_st.bit_count = 4'd0;
                if (bus_st.byte_index == BYTE_ADDR) begin
                    bus_st.byte_index = BYTE_FIRST;
                    if (bus_st.is_read) begin
                        bus_st.shift_byte = 8'd0;
                        bus_st.phase      = PH_RBIT_HIGH;
                    end else begin
                        bus_st.shift_byte = bus_st.held_data;
                        bus_st.phase      = PH_WBIT_SET;
                    end
                end else begin
                    bus_st.phase = PH_STOP1;
                end
            end
            PH_RBIT_HIGH: begin
                bus_st.sda_drive = 1'b0;
                bus_st.scl       = 1'b1;
                bus_st.phase     = PH_RBIT_SAMPLE;
            end
            PH_RBIT_SAMPLE: begin
                bus_st.shift_byte = {bus_st.shift_byte[6:0], sda};
                bus_st.scl        = 1'b0;
                bus_st.bit_count  = bus_st.bit_count + 4'd1;
                bus_st.phase = (bus_st.bit_count >= BITS_PER_BYTE) ? PH_MACK_SET
                                                                   : PH_RBIT_HIGH;
            end
            PH_MACK_SET: begin
                bus_st.sda_drive = 1'b1;
                if (bus_st.byte_index == BYTE_FIRST) begin
                    bus_st.read_word = {bus_st.shift_byte, 8'h00};
                    bus_st.sda       = 1'b0;
                end else begin
                    bus_st.read_word[7:0] = bus_st.shift_byte;
                    bus_st.sda            = 1'b1;
                end
                bus_st.phase = PH_MACK_HIGH;
            end
            PH_MACK_HIGH: begin
                bus_st.scl   = 1'b1;
                bus_st.phase = PH_MACK_LOW;
            end
            PH_MACK_LOW: begin
                bus_st.scl = 1'b0;
                if (bus_st.byte_index == BYTE_FIRST) begin
                    bus_st.byte_index = BYTE_SECOND;
                    bus_st.shift_byte = 8'd0;
                    bus_st.bit_count  = 4'd0;
                    bus_st.phase      = PH_RBIT_HIGH;
                end else begin
                    bus_st.phase = PH_STOP1;
                end
            end
            PH_STOP1: begin
                bus_st.sda_drive = 1'b1;
                bus_st.scl       = 1'b0;
                bus_st.sda       = 1'b0;
                bus_st.phase     = PH_STOP2;
            end
            PH_STOP2: begin
                bus_st.scl   = 1'b1;
                bus_st.phase = PH_STOP3;
            end
            PH_STOP3: begin
                bus_st.sda   = 1'b1;
                bus_st.phase = PH_DONE;
            end
            PH_DONE: begin
                done         = 1'b1;
                bus_st.phase = PH_IDLE;
            end
            default: bus_st.phase = PH_IDLE;
        endcase
        pins.scl       = bus_st.scl;
        pins.sda_level = bus_st.sda;
        pins.sda_drive = bus_st.sda_drive;
        pins.busy      = (bus_st.phase != PH_IDLE);
        pins.done      = done;
        pins.read_word = bus_st.read_word;
        pins.nack      = bus_st.nack_seen;
    endtask

    task automatic send_tick(input logic [1:0] act, input logic [6:0] addr,
                             input logic [7:0] wdata, input logic sda);
        t_bus_pins pins;
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.target_addr <= addr;
        in_ch.write_data  <= wdata;
        in_ch.sda_in      <= sda;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        step_bus_model(act, addr, wdata, sda, pins);
        expected_pins.push_back(pins);
        ticks_sent++;
    endtask

    // Finish any open transfer with noise, then run one transfer while acting
    // as the slave: ack levels and read bits go out in the sample ticks.
    task automatic run_transfer(input logic [1:0] act, input logic [6:0] addr,
                                input logic [7:0] wdata, input logic addr_nack,
                                input logic data_nack, input logic [15:0] rd_val,
                                input int busy_noise_pct);
        logic [1:0] busy_act;
        logic       sda;
        while (bus_st.phase != PH_IDLE)
            send_tick(2'($urandom_range(3)), 7'($urandom), 8'($urandom),
                      1'($urandom_range(1)));
        send_tick(act, addr, wdata, 1'($urandom_range(1)));
        while (bus_st.phase != PH_IDLE) begin
            busy_act = ACT_TICK;
            if ($urandom_range(99) < busy_noise_pct || (bus_st.phase == PH_DONE &&
                                                        busy_noise_pct > 0))
                busy_act = 2'($urandom_range(1, 3));
            case (bus_st.phase)
                PH_ACK_SAMPLE:
                    sda = (bus_st.byte_index == BYTE_ADDR) ? addr_nack : data_nack;
                PH_RBIT_SAMPLE:
                    sda = (bus_st.byte_index == BYTE_FIRST) ?
                          rd_val[15 - bus_st.bit_count] : rd_val[7 - bus_st.bit_count];
                default:
                    sda = 1'($urandom_range(1));
            endcase
            send_tick(busy_act, 7'($urandom), 8'($urandom), sda);
        end
    endtask

    task automatic test_idle_ticks();
        send_tick(ACT_TICK, 7'h00, 8'h00, 1'b0);
        send_tick(ACT_RSVD, 7'h7F, 8'hFF, 1'b1);
        send_tick(ACT_TICK, 7'h7F, 8'hFF, 1'b1);
        send_tick(ACT_RSVD, 7'h00, 8'h00, 1'b0);
    endtask

    task automatic test_write_transfer();
        run_transfer(ACT_WRITE, 7'h00, 8'hFF, 1'b0, 1'b0, 16'h0000, 30);
        // data byte not acknowledged
        run_transfer(ACT_WRITE, 7'h7F, 8'h00, 1'b0, 1'b1, 16'h0000, 0);
    endtask

    task automatic test_read_transfer();
        // address nack, read goes on anyway
        run_transfer(ACT_READ, 7'h7F, 8'hFF, 1'b1, 1'b0, 16'hFF00, 30);
        run_transfer(ACT_READ, 7'h00, 8'h00, 1'b0, 1'b1, 16'h00FF, 0);
    endtask

    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_reqs   <= hold_reqs + 1;
        run_transfer(ACT_WRITE, 7'($urandom), 8'($urandom), 1'b0, 1'b0, 16'h0000, 0);
    endtask

    task automatic test_random(input int tx_pct, input int rx_pct);
        int stop_at;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        stop_at      = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                repeat ($urandom_range(1, 6))
                    send_tick(2'($urandom_range(3)), 7'($urandom), 8'($urandom),
                              1'($urandom_range(1)));
            end else begin
                run_transfer(2'($urandom_range(1, 2)), 7'($urandom), 8'($urandom),
                             $urandom_range(99) < 20, $urandom_range(99) < 20,
                             16'($urandom), 10);
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.action      <= ACT_TICK;
        in_ch.target_addr <= 7'd0;
        in_ch.write_data  <= 8'd0;
        in_ch.sda_in      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct  = 7;
        rx_stall_pct = 80;
        test_idle_ticks();
        test_write_transfer();
        test_read_transfer();
        test_backpressure();
        test_random(7, 80);
        test_random(80, 7);
        test_random(0, 0);
        in_ch.valid <= 1'b0;

        while (expected_pins.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0)
            $display("i2c_master_transaction_top_tb: clean");
        else
            $display("i2c_master_transaction_top_tb: errors");
        $finish;
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Status word checker and receiver stall control.
    initial begin
        t_bus_pins want;
        int        hold_left;
        int        hold_served;
        hold_left    = 0;
        hold_served  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (expected_pins.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word expected none actual %0h", $time,
                             out_ch.read_word);
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl", 16'(want.scl), 16'(out_ch.scl));
                    check_field("sda_level", 16'(want.sda_level), 16'(out_ch.sda_level));
                    check_field("sda_drive", 16'(want.sda_drive), 16'(out_ch.sda_drive));
                    check_field("busy_res", 16'(want.busy), 16'(out_ch.busy_res));
                    check_field("done_res", 16'(want.done), 16'(out_ch.done_res));
                    check_field("read_word", want.read_word, out_ch.read_word);
                    check_field("nack", 16'(want.nack), 16'(out_ch.nack));
                end
            end
            if (hold_reqs != hold_served) begin
                hold_served = hold_reqs;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        #2000000;
        $display("i2c_master_transaction_top_tb: errors");
        $finish;
    end

endmodule

// ===== i2c_master_transaction_top.f =====
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_if.sv
sv/i2cm_step.sv
sv/i2c_master_transaction_top.sv
tb/i2c_master_transaction_top_tb.sv
